/* rtl/qers_pkg.sv */
// Shared types and constants for the quadratic equation root solver.
// Holds the coefficient and result beat structs and the root count codes.
// No dependencies.
`default_nettype none

package qers_pkg;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int TOL_W = 16;
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;
	localparam int FIFO_DEPTH = 128;

	localparam logic [APB_AW-1:0] ADDR_ZERO_TOL = 3'd0;

	typedef enum logic [1:0] {
		CNT_NONE = 2'd0,
		CNT_ONE  = 2'd1,
		CNT_TWO  = 2'd2,
		CNT_INF  = 2'd3
	} root_cnt_t;

	typedef struct packed {
		logic signed [CW-1:0] coef_quad;
		logic signed [CW-1:0] coef_lin;
		logic signed [CW-1:0] coef_free;
	} coef_t;

	typedef struct packed {
		logic [1:0]           root_count;
		logic signed [CW-1:0] root_first;
		logic signed [CW-1:0] root_second;
		logic                 is_linear;
		logic                 overflow;
	} root_t;

endpackage

`default_nettype wire

/* rtl/quadratic_equation_root_solver.sv */
// Top level of the quadratic equation root solver: classifier, pipelined
// square root, two pipelined dividers and an output queue.
// Depends on qers_pkg.
//
// Use: coefficient beats (a, b, c in signed Q16.16) enter on coef/coef_valid/
// coef_ready; result beats leave on root/root_valid/root_ready. The APB port
// holds one register, the zero tolerance, at address 0.
// The datapath has no stalls of its own: one beat enters every cycle while coef_ready is high. It is
// three front stages (magnitudes, products, discriminant and case split), a
// 33 stage square root that resolves one root bit per stage, one stage that
// forms the numerators, and two 50 stage restoring dividers that resolve one
// quotient bit per stage.
// Finished results land in a 128 entry queue in front of the output register.
// A credit counter holds coef_ready low only when 128 beats are in flight or
// waiting, so a stalled receiver never loses a result and a short stall does
// not stop the input side.
// Reset empties the pipeline and the queue and sets the tolerance to 1.
`default_nettype none

module quadratic_equation_root_solver (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire qers_pkg::coef_t              coef,
	input  wire logic                         coef_valid,
	output logic                              coef_ready,
	output qers_pkg::root_t                   root,
	output logic                              root_valid,
	input  wire logic                         root_ready,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [qers_pkg::APB_AW-1:0]  paddr,
	input  wire logic [qers_pkg::APB_DW-1:0]  pwdata,
	output logic [qers_pkg::APB_DW-1:0]       prdata,
	output logic                              pready
);
	import qers_pkg::*;

	localparam int DW  = 2 * CW + 2;   // discriminant magnitude
	localparam int SW  = DW / 2;       // square root result
	localparam int RW  = SW + 3;       // square root remainder
	localparam int NW  = SW + 2;       // signed numerator
	localparam int NM  = NW - 1;       // numerator magnitude
	localparam int DN  = CW + 1;       // signed denominator
	localparam int QW  = NM + FB;      // dividend and quotient
	localparam int DRW = DN + 1;       // divider remainder
	localparam int PW  = $clog2(FIFO_DEPTH);
	localparam int CNW = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_FIXED,
		MODE_DIV,
		MODE_SQRT
	} mode_t;

	typedef struct packed {
		mode_t                mode;
		logic [1:0]           cnt;
		logic                 lin;
		logic signed [CW-1:0] b;
		logic signed [DN-1:0] den;
		logic signed [NW-1:0] n1;
	} side_t;

	// Configuration.
	logic [TOL_W-1:0] tol_q;
	logic             cfg_wr;

	assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == ADDR_ZERO_TOL[APB_AW-1:2]);
	assign pready = 1'b1;
	assign prdata = (paddr[APB_AW-1:2] == ADDR_ZERO_TOL[APB_AW-1:2]) ?
		APB_DW'(tol_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_W'(1);
		end else if (cfg_wr) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	// Credit counter and input handshake.
	logic [CNW-1:0] busy_q;
	logic           in_acc;
	logic           out_acc;

	assign coef_ready = (busy_q < CNW'(FIFO_DEPTH));
	assign in_acc     = coef_valid && coef_ready;
	assign out_acc    = root_valid && root_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			busy_q <= busy_q + CNW'(in_acc) - CNW'(out_acc);
		end
	end

	// Stage 1: magnitudes and near-zero tests.
	logic                 v_s1;
	logic signed [CW-1:0] a_s1, b_s1, c_s1;
	logic [CW-1:0]        ma_s1, mb_s1, mc_s1;
	logic                 nza_s1, nzb_s1, nzc_s1;
	logic [CW-1:0]        ma_c, mb_c, mc_c;

	assign ma_c = coef.coef_quad[CW-1] ? CW'(-coef.coef_quad) : coef.coef_quad;
	assign mb_c = coef.coef_lin[CW-1]  ? CW'(-coef.coef_lin)  : coef.coef_lin;
	assign mc_c = coef.coef_free[CW-1] ? CW'(-coef.coef_free) : coef.coef_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		a_s1   <= coef.coef_quad;
		b_s1   <= coef.coef_lin;
		c_s1   <= coef.coef_free;
		ma_s1  <= ma_c;
		mb_s1  <= mb_c;
		mc_s1  <= mc_c;
		nza_s1 <= (ma_c == '0) || (ma_c < CW'(tol_q));
		nzb_s1 <= (mb_c == '0) || (mb_c < CW'(tol_q));
		nzc_s1 <= (mc_c == '0) || (mc_c < CW'(tol_q));
	end

	// Stage 2: b*b and a*c.
	logic                 v_s2;
	logic signed [CW-1:0] a_s2, b_s2, c_s2;
	logic [2*CW-1:0]      bb_s2, ac_s2;
	logic                 acneg_s2, nza_s2, nzb_s2, nzc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_s2     <= a_s1;
		b_s2     <= b_s1;
		c_s2     <= c_s1;
		bb_s2    <= mb_s1 * mb_s1;
		ac_s2    <= ma_s1 * mc_s1;
		acneg_s2 <= a_s1[CW-1] ^ c_s1[CW-1];
		nza_s2   <= nza_s1;
		nzb_s2   <= nzb_s1;
		nzc_s2   <= nzc_s1;
	end

	// Stage 3: discriminant and case split.
	logic          v_s3;
	side_t         side_s3;
	logic [DW-1:0] dm_s3;
	logic [DW-1:0] ac4_c, bbx_c, dm_c, tol_c;
	logic          dneg_c;
	side_t         side_c;

	always_comb begin
		ac4_c = {ac_s2, 2'b00};
		bbx_c = DW'(bb_s2);
		tol_c = DW'({tol_q, FB'(0)});
		dneg_c = 1'b0;
		if (acneg_s2) begin
			dm_c = bbx_c + ac4_c;
		end else if (bbx_c >= ac4_c) begin
			dm_c = bbx_c - ac4_c;
		end else begin
			dm_c = ac4_c - bbx_c;
			dneg_c = 1'b1;
		end

		side_c.b    = b_s2;
		side_c.lin  = nza_s2;
		side_c.den  = {a_s2, 1'b0};
		side_c.n1   = -NW'(b_s2);
		side_c.mode = MODE_FIXED;
		side_c.cnt  = CNT_NONE;
		if (nza_s2) begin
			side_c.den = DN'(b_s2);
			side_c.n1  = -NW'(c_s2);
			if (nzb_s2) begin
				side_c.cnt = nzc_s2 ? CNT_INF : CNT_NONE;
			end else begin
				side_c.cnt  = CNT_ONE;
				side_c.mode = MODE_DIV;
			end
		end else if (dneg_c && (dm_c > tol_c)) begin
			side_c.cnt = CNT_NONE;
		end else if (dneg_c || (dm_c < tol_c) || (dm_c == '0)) begin
			side_c.cnt  = CNT_ONE;
			side_c.mode = MODE_DIV;
		end else begin
			side_c.cnt  = CNT_TWO;
			side_c.mode = MODE_SQRT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_c;
		dm_s3   <= dm_c;
	end

	// Square root: one result bit per stage.
	logic          sq_v_s    [SW+1];
	side_t         sq_side_s [SW+1];
	logic [DW-1:0] sq_x_s    [SW+1];
	logic [RW-1:0] sq_rem_s  [SW+1];
	logic [SW-1:0] sq_root_s [SW+1];

	assign sq_v_s[0]    = v_s3;
	assign sq_side_s[0] = side_s3;
	assign sq_x_s[0]    = dm_s3;
	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;

	for (genvar k = 0; k < SW; k++) begin : g_sqrt
		logic [RW-1:0] pre, trial;
		logic          fit;

		assign pre   = {sq_rem_s[k][RW-3:0], sq_x_s[k][DW-1:DW-2]};
		assign trial = {1'b0, sq_root_s[k], 2'b01};
		assign fit   = (pre >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			sq_side_s[k+1] <= sq_side_s[k];
			sq_x_s[k+1]    <= {sq_x_s[k][DW-3:0], 2'b00};
			sq_rem_s[k+1]  <= fit ? (pre - trial) : pre;
			sq_root_s[k+1] <= {sq_root_s[k][SW-2:0], fit};
		end
	end

	// Numerators, signs and magnitudes for the dividers.
	logic          dv_v_s    [QW+1];
	mode_t         dv_mode_s [QW+1];
	logic [1:0]    dv_cnt_s  [QW+1];
	logic          dv_lin_s  [QW+1];
	logic          dv_neg1_s [QW+1];
	logic          dv_neg2_s [QW+1];
	logic [DN-1:0] dv_den_s  [QW+1];
	logic [QW-1:0] dv_x1_s   [QW+1];
	logic [QW-1:0] dv_x2_s   [QW+1];
	logic [DN-1:0] dv_rem1_s [QW+1];
	logic [DN-1:0] dv_rem2_s [QW+1];
	logic [QW-1:0] dv_q1_s   [QW+1];
	logic [QW-1:0] dv_q2_s   [QW+1];

	side_t                sq_out;
	logic signed [NW-1:0] n1_c, n2_c, nb_c, s_c;
	logic [NM-1:0]        m1_c, m2_c;

	assign sq_out = sq_side_s[SW];

	always_comb begin
		s_c  = NW'(sq_root_s[SW]);
		nb_c = -NW'(sq_out.b);
		if (sq_out.mode == MODE_SQRT) begin
			n1_c = nb_c + s_c;
			n2_c = nb_c - s_c;
		end else begin
			n1_c = sq_out.n1;
			n2_c = sq_out.n1;
		end
		m1_c = n1_c[NW-1] ? NM'(-n1_c) : NM'(n1_c);
		m2_c = n2_c[NW-1] ? NM'(-n2_c) : NM'(n2_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else begin
			dv_v_s[0] <= sq_v_s[SW];
		end
	end

	always_ff @(posedge clk) begin
		dv_mode_s[0] <= sq_out.mode;
		dv_cnt_s[0]  <= sq_out.cnt;
		dv_lin_s[0]  <= sq_out.lin;
		dv_neg1_s[0] <= n1_c[NW-1] ^ sq_out.den[DN-1];
		dv_neg2_s[0] <= n2_c[NW-1] ^ sq_out.den[DN-1];
		dv_den_s[0]  <= sq_out.den[DN-1] ? DN'(-sq_out.den) : DN'(sq_out.den);
		dv_x1_s[0]   <= {m1_c, FB'(0)};
		dv_x2_s[0]   <= {m2_c, FB'(0)};
		dv_rem1_s[0] <= '0;
		dv_rem2_s[0] <= '0;
		dv_q1_s[0]   <= '0;
		dv_q2_s[0]   <= '0;
	end

	// Two restoring dividers: one quotient bit per stage.
	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [DRW-1:0] pre1, pre2, dext;
		logic           fit1, fit2;

		assign dext = {1'b0, dv_den_s[j]};
		assign pre1 = {dv_rem1_s[j], dv_x1_s[j][QW-1]};
		assign pre2 = {dv_rem2_s[j], dv_x2_s[j][QW-1]};
		assign fit1 = (pre1 >= dext);
		assign fit2 = (pre2 >= dext);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			dv_mode_s[j+1] <= dv_mode_s[j];
			dv_cnt_s[j+1]  <= dv_cnt_s[j];
			dv_lin_s[j+1]  <= dv_lin_s[j];
			dv_neg1_s[j+1] <= dv_neg1_s[j];
			dv_neg2_s[j+1] <= dv_neg2_s[j];
			dv_den_s[j+1]  <= dv_den_s[j];
			dv_x1_s[j+1]   <= {dv_x1_s[j][QW-2:0], 1'b0};
			dv_x2_s[j+1]   <= {dv_x2_s[j][QW-2:0], 1'b0};
			dv_rem1_s[j+1] <= fit1 ? DN'(pre1 - dext) : DN'(pre1);
			dv_rem2_s[j+1] <= fit2 ? DN'(pre2 - dext) : DN'(pre2);
			dv_q1_s[j+1]   <= {dv_q1_s[j][QW-2:0], fit1};
			dv_q2_s[j+1]   <= {dv_q2_s[j][QW-2:0], fit2};
		end
	end

	// Saturation to the signed coefficient range.
	logic [QW-1:0]        lim1_c, lim2_c;
	logic                 ov1_c, ov2_c;
	logic [QW-1:0]        sm1_c, sm2_c;
	root_t                res_c;

	always_comb begin
		lim1_c = dv_neg1_s[QW] ? (QW'(1) << (CW - 1)) : ((QW'(1) << (CW - 1)) - QW'(1));
		lim2_c = dv_neg2_s[QW] ? (QW'(1) << (CW - 1)) : ((QW'(1) << (CW - 1)) - QW'(1));
		ov1_c  = (dv_q1_s[QW] > lim1_c);
		ov2_c  = (dv_q2_s[QW] > lim2_c);
		sm1_c  = ov1_c ? lim1_c : dv_q1_s[QW];
		sm2_c  = ov2_c ? lim2_c : dv_q2_s[QW];

		res_c.root_count = dv_cnt_s[QW];
		res_c.is_linear  = dv_lin_s[QW];
		if (dv_mode_s[QW] == MODE_FIXED) begin
			res_c.root_first  = '0;
			res_c.root_second = '0;
			res_c.overflow    = 1'b0;
		end else begin
			res_c.root_first  = dv_neg1_s[QW] ? CW'(-sm1_c) : CW'(sm1_c);
			res_c.root_second = dv_neg2_s[QW] ? CW'(-sm2_c) : CW'(sm2_c);
			res_c.overflow    = ov1_c | ov2_c;
		end
	end

	// Output queue and output register.
	root_t          fifo_mem [FIFO_DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNW-1:0] fifo_cnt_q;
	logic           fifo_wr, fifo_rd;

	assign fifo_wr = dv_v_s[QW];
	assign fifo_rd = (fifo_cnt_q != '0) && (!root_valid || root_ready);

	always_ff @(posedge clk) begin
		if (fifo_wr) begin
			fifo_mem[wr_ptr_q] <= res_c;
		end
		if (fifo_rd) begin
			root <= fifo_mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			root_valid <= 1'b0;
		end else begin
			wr_ptr_q   <= wr_ptr_q + PW'(fifo_wr);
			rd_ptr_q   <= rd_ptr_q + PW'(fifo_rd);
			fifo_cnt_q <= fifo_cnt_q + CNW'(fifo_wr) - CNW'(fifo_rd);
			root_valid <= fifo_rd || (root_valid && !root_ready);
		end
	end

	// Checks.
	a_busy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q <= CNW'(FIFO_DEPTH))
		else $error("in-flight count exceeds queue depth");

	a_queue_covered: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= busy_q)
		else $error("queue holds more beats than are in flight");

	a_out_credit: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid |-> (busy_q != '0))
		else $error("result shown with no beat in flight");

	a_no_overflow_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_wr && ((res_c.root_count == CNT_NONE) || (res_c.root_count == CNT_INF)))
		|-> (!res_c.overflow && (res_c.root_first == '0)))
		else $error("root value set for a no-root or every-root result");

endmodule

`default_nettype wire

/* tb/qers_checker.sv */
// Checker for the quadratic equation root solver: watches both beat channels,
// predicts each result from the coefficients and the tolerance, and compares.
// Depends on qers_pkg.
module qers_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire qers_pkg::coef_t  coef,
	input wire logic             coef_valid,
	input wire logic             coef_ready,
	input wire qers_pkg::root_t  root,
	input wire logic             root_valid,
	input wire logic             root_ready,
	input wire logic [15:0]      tolerance,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import qers_pkg::*;

	root_t roots_due[$];

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic is_zeroish(input logic signed [63:0] v, input logic [15:0] tol);
		logic [63:0] m;
		m = mag64(v);
		return m == 0 || m < tol;
	endfunction

	// Truncating quotient in Q16.16 with saturation to the 32-bit range.
	function automatic logic [31:0] fixed_div(input logic signed [63:0] num,
			input logic signed [63:0] den, inout logic ovf);
		logic [127:0] q;
		logic [63:0] lim;
		logic [63:0] m;
		logic neg;
		neg = (num < 0) != (den < 0);
		q = ({64'd0, mag64(num)} << FB) / {64'd0, mag64(den)};
		lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
		if (q > {64'd0, lim}) begin
			m = lim;
			ovf = 1'b1;
		end else begin
			m = q[63:0];
		end
		return neg ? 32'(-m) : 32'(m);
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [127:0] x);
		logic [127:0] r;
		logic [127:0] b;
		r = 0;
		b = 128'd1 << 126;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[63:0];
	endfunction

	function automatic root_t solve_roots(input coef_t c, input logic [15:0] tol);
		root_t r;
		logic signed [63:0] qa, lb, fc, s;
		logic [127:0] bb, ac4, dm, thr;
		logic dneg, ovf;
		qa = c.coef_quad;
		lb = c.coef_lin;
		fc = c.coef_free;
		r = '0;
		ovf = 1'b0;
		thr = 128'(tol) << FB;
		if (is_zeroish(qa, tol)) begin
			r.is_linear = 1'b1;
			if (is_zeroish(lb, tol)) begin
				r.root_count = is_zeroish(fc, tol) ? CNT_INF : CNT_NONE;
			end else begin
				r.root_count = CNT_ONE;
				r.root_first = fixed_div(-fc, lb, ovf);
				r.root_second = r.root_first;
			end
		end else begin
			bb = 128'(mag64(lb)) * 128'(mag64(lb));
			ac4 = (128'(mag64(qa)) * 128'(mag64(fc))) << 2;
			dneg = 1'b0;
			if ((qa < 0) != (fc < 0)) dm = bb + ac4;
			else if (bb >= ac4) dm = bb - ac4;
			else begin
				dm = ac4 - bb;
				dneg = 1'b1;
			end
			if (dneg && dm > thr) begin
				r.root_count = CNT_NONE;
			end else if (dneg || dm < thr || dm == 0) begin
				r.root_count = CNT_ONE;
				r.root_first = fixed_div(-lb, 2 * qa, ovf);
				r.root_second = r.root_first;
			end else begin
				s = int_sqrt(dm);
				r.root_count = CNT_TWO;
				r.root_first = fixed_div(-lb + s, 2 * qa, ovf);
				r.root_second = fixed_div(-lb - s, 2 * qa, ovf);
			end
		end
		r.overflow = ovf;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		root_t want;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			roots_due.delete();
		end else begin
			if (coef_valid && coef_ready) roots_due.push_back(solve_roots(coef, tolerance));
			if (root_valid && root_ready) begin
				if (roots_due.size() == 0) begin
					$display("%t unexpected result beat %p", $time, root);
					fail_count <= fail_count + 1;
				end else begin
					want = roots_due.pop_front();
					if (root !== want) begin
						$display("%t mismatch: expected %p actual %p", $time, want, root);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= roots_due.size();
		end
	end
endmodule

/* tb/testbench.sv */
// Top of the root solver testbench: clock, reset, APB tolerance writes,
// coefficient stimulus and result back-pressure. Depends on qers_pkg,
// qers_checker and the solver RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import qers_pkg::*;

	localparam int RANDOM_ITEMS = 650;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	coef_t coef;
	logic coef_valid;
	logic coef_ready;
	root_t root;
	logic root_valid;
	logic root_ready;
	logic psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic [15:0] tolerance;
	int fail_count;
	int pending;
	int idle_cycles;
	int sent;
	logic timed_out;

	quadratic_equation_root_solver uut (.*);

	qers_checker checker_i (.clk, .arst_n, .coef, .coef_valid, .coef_ready, .root,
		.root_valid, .root_ready, .tolerance, .fail_count, .pending);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] pick_coef(input logic [15:0] tol);
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(signed'($urandom_range(0, 2 * tol + 2)) - signed'(32'(tol)) - 1);
			3, 4: return 32'(signed'($urandom_range(0, 20 << 16)) - (10 << 16));
			5: return 32'(signed'($urandom_range(0, 1 << 12)) - (1 << 11));
			default: return $urandom();
		endcase
	endfunction

	// Mostly short pauses, occasionally a long one.
	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic write_tolerance(input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_ZERO_TOL;
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		tolerance = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Valid stays high between back-to-back beats and drops only for a gap.
	task automatic send_coef(input logic [31:0] qa, input logic [31:0] lb,
			input logic [31:0] fc);
		int g;
		g = gap_len();
		if (g > 0) begin
			coef_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		coef <= '{qa, lb, fc};
		coef_valid <= 1'b1;
		do @(posedge clk); while (!coef_ready);
		sent++;
	endtask

	task automatic drain();
		coef_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		int stall;
		root_ready = 1'b0;
		forever begin
			@(posedge clk);
			stall = ($urandom_range(0, 99) < 8) ? gap_len() : 0;
			if (stall > 0) begin
				root_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			root_ready <= 1'b1;
		end
	end

	initial begin
		timed_out = 1'b0;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((coef_valid && coef_ready) || (root_valid && root_ready) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", pending);
				$display("[quadratic_equation_root_solver] ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] tols [4];
		arst_n = 1'b0;
		coef = '0;
		coef_valid = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tolerance = 16'd1;
		sent = 0;
		tols = '{16'd0, 16'hffff, 16'd300, 16'd1};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats at the reset tolerance.
		send_coef(0, 0, 0);
		send_coef(0, 0, 32'h0001_0000);
		send_coef(0, 32'h0002_0000, 32'hfffc_0000);
		send_coef(0, 32'h0000_0001, 32'h7fff_ffff);
		send_coef(0, 32'h0000_0001, 32'h8000_0000);
		send_coef(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);
		send_coef(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
		send_coef(32'h0001_0000, 0, 32'h0001_0000);
		send_coef(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_coef(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_coef(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		send_coef(32'h0000_0002, 32'h7fff_ffff, 32'h8000_0000);
		send_coef(32'hffff_ffff, 32'h0000_0001, 32'h0000_0001);
		send_coef(32'h0000_0001, 32'h8000_0000, 0);
		drain();

		// Tolerance 0: only exact zero counts as zero.
		write_tolerance(16'd0);
		send_coef(0, 32'h0000_0001, 32'h0000_0001);
		send_coef(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);
		drain();

		// Largest tolerance: includes D exactly at minus and plus the threshold.
		write_tolerance(16'hffff);
		send_coef(32'h0000_ffff, 32'h0001_0000, 0);
		send_coef(32'h0001_0000, 32'h0000_ffff, 32'h0001_0000);
		send_coef(32'h0000_4000, 0, 32'h0000_ffff);
		send_coef(32'h0000_4000, 0, 32'hffff_0001);
		send_coef(32'h0001_0000, 32'h0000_ffff, 32'h0000_fffe);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_tolerance(ph == 3 ? 16'($urandom()) : tols[ph]);
			for (int i = 0; i < RANDOM_ITEMS / 4; i++)
				send_coef(pick_coef(tolerance), pick_coef(tolerance), pick_coef(tolerance));
			drain();
		end

		$display("Sent %0d coefficient beats over five tolerance settings, including 0 and 65535,",
			sent);
		$display("covering linear, degenerate, no-root, one-root, two-root and saturating cases.");
		if (fail_count == 0 && pending == 0) begin
			$display("[quadratic_equation_root_solver] OK");
		end else begin
			$display("[quadratic_equation_root_solver] ERROR");
		end
		$finish;
	end
endmodule
